FILE: rtl/core/pefb_pkg.sv
// Shared constants, register codes and types for the photon event frame binner.
`default_nettype none

package pefb_pkg;

  // Field widths of the configuration registers and results.
  localparam int CX_W  = 10;
  localparam int SZ_W  = 9;
  localparam int RF_W  = 6;
  localparam int PS_W  = 16;
  localparam int FN_W  = 20;
  localparam int KT_W  = 32;
  localparam int PIX_W = 16;
  localparam int EVT_W = 32;

  // Largest binned image edge; sizes are saturated at this value rounded down to even.
  localparam int unsigned MAX_IMAGE = 256;

  // Default coordinate width of the event word.
  localparam int DEF_COORD_BITS = 10;

  // Configuration port geometry.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_CENTER_X      = 3'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_Y      = 3'd1;
  localparam logic [IDX_W-1:0] REG_OUT_WIDTH     = 3'd2;
  localparam logic [IDX_W-1:0] REG_OUT_HEIGHT    = 3'd3;
  localparam logic [IDX_W-1:0] REG_REDUCE_FACTOR = 3'd4;
  localparam logic [IDX_W-1:0] REG_PACK_SIZE     = 3'd5;

  // Reset values of the registers.
  localparam logic [CX_W-1:0] RST_CENTER = 10'd512;
  localparam logic [SZ_W-1:0] RST_SIZE   = 9'd256;
  localparam logic [RF_W-1:0] RST_REDUCE = 6'd4;
  localparam logic [PS_W-1:0] RST_PACK   = 16'd100;

  // Current register contents.
  typedef struct packed {
    logic [CX_W-1:0] center_x;
    logic [CX_W-1:0] center_y;
    logic [SZ_W-1:0] out_width;
    logic [SZ_W-1:0] out_height;
    logic [RF_W-1:0] reduce_factor;
    logic [PS_W-1:0] pack_size;
  } pefb_cfg_t;

  // Frame bookkeeping results for one photon.
  typedef struct packed {
    logic            a_done;
    logic            b_done;
    logic            b_restart;
    logic [FN_W-1:0] frame_number;
    logic [KT_W-1:0] photons_kept;
  } pefb_pack_t;

endpackage

`default_nettype wire

FILE: rtl/core/pefb_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module pefb_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pefb_pkg::ADDR_W-1:0] paddr,
  input  wire logic [pefb_pkg::DATA_W-1:0] pwdata,
  output logic      [pefb_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output pefb_pkg::pefb_cfg_t             cfg
);
  import pefb_pkg::*;

  pefb_cfg_t        cfg_r;
  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x      <= RST_CENTER;
      cfg_r.center_y      <= RST_CENTER;
      cfg_r.out_width     <= RST_SIZE;
      cfg_r.out_height    <= RST_SIZE;
      cfg_r.reduce_factor <= RST_REDUCE;
      cfg_r.pack_size     <= RST_PACK;
    end else if (wr_en) begin
      case (idx)
        REG_CENTER_X:      cfg_r.center_x      <= pwdata[CX_W-1:0];
        REG_CENTER_Y:      cfg_r.center_y      <= pwdata[CX_W-1:0];
        REG_OUT_WIDTH:     cfg_r.out_width     <= pwdata[SZ_W-1:0];
        REG_OUT_HEIGHT:    cfg_r.out_height    <= pwdata[SZ_W-1:0];
        REG_REDUCE_FACTOR: cfg_r.reduce_factor <= pwdata[RF_W-1:0];
        REG_PACK_SIZE:     cfg_r.pack_size     <= pwdata[PS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    prdata = '0;
    case (idx)
      REG_CENTER_X:      prdata = DATA_W'(cfg_r.center_x);
      REG_CENTER_Y:      prdata = DATA_W'(cfg_r.center_y);
      REG_OUT_WIDTH:     prdata = DATA_W'(cfg_r.out_width);
      REG_OUT_HEIGHT:    prdata = DATA_W'(cfg_r.out_height);
      REG_REDUCE_FACTOR: prdata = DATA_W'(cfg_r.reduce_factor);
      REG_PACK_SIZE:     prdata = DATA_W'(cfg_r.pack_size);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/pefb_div.sv
// Shared restoring divider, two quotient bits per cycle, for the coordinate binning.
`default_nettype none

module pefb_div #(
  parameter int COORD_BITS = pefb_pkg::DEF_COORD_BITS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [COORD_BITS-1:0]      dividend,
  input  wire logic [pefb_pkg::RF_W-1:0]  divisor,
  output logic                            busy,
  output logic                            done,
  output logic      [COORD_BITS-1:0]      quotient
);
  import pefb_pkg::*;

  localparam int QW    = COORD_BITS + (COORD_BITS % 2);
  localparam int NSTEP = QW / 2;
  localparam int CW    = $clog2(NSTEP);
  localparam logic [CW-1:0] LAST = CW'(NSTEP - 1);

  logic [QW-1:0]   q_r, q_nxt;
  logic [RF_W-1:0] rem_r, rem_nxt;
  logic [CW-1:0]   cnt_r;
  logic            busy_r, done_r;

  // Two restoring steps: shift in the next dividend bit, subtract when it fits.
  always_comb begin
    logic [RF_W:0] trial;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_nxt, q_nxt[QW-1]};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = RF_W'(trial - {1'b0, divisor});
        q_nxt   = {q_nxt[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[RF_W-1:0];
        q_nxt   = {q_nxt[QW-2:0], 1'b0};
      end
    end
  end

  // Step sequencing; done pulses for one cycle after the last step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      q_r   <= QW'(dividend);
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r[COORD_BITS-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/pefb_pack.sv
// Interleaved pack counters, frame numbering and kept-photon count.
`default_nettype none

module pefb_pack (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire logic                       kept,
  input  wire logic [pefb_pkg::PS_W-1:0]  pack_size,
  output pefb_pkg::pefb_pack_t            res
);
  import pefb_pkg::*;

  logic [PS_W-1:0] cnt_a_r, cnt_a_nxt;
  logic [PS_W-1:0] cnt_b_r, cnt_b_nxt;
  logic [FN_W-1:0] frames_r, frames_nxt;
  logic [KT_W-1:0] kept_r, kept_nxt;
  logic            any_r, any_nxt;

  // Checks run on every photon, kept or not.
  always_comb begin
    logic [PS_W-1:0] a1, b1;
    logic            adone, bdone, restart, any_a;
    a1       = kept ? cnt_a_r + 1'b1 : cnt_a_r;
    b1       = kept ? cnt_b_r + 1'b1 : cnt_b_r;
    kept_nxt = kept ? kept_r + 1'b1 : kept_r;
    adone    = (a1 == pack_size);
    cnt_a_nxt = adone ? '0 : a1;
    any_a    = any_r || adone;
    restart  = !any_a && (cnt_a_nxt == (pack_size >> 1));
    b1       = restart ? '0 : b1;
    bdone    = (b1 == pack_size);
    cnt_b_nxt = bdone ? '0 : b1;
    any_nxt  = any_a || bdone;
    frames_nxt = frames_r + FN_W'(adone) + FN_W'(bdone);

    res.a_done       = adone;
    res.b_done       = bdone;
    res.b_restart    = restart;
    res.frame_number = frames_r;
    res.photons_kept = kept_nxt;
  end

  // State update once per delivered photon.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r  <= '0;
      cnt_b_r  <= '0;
      frames_r <= '0;
      kept_r   <= '0;
      any_r    <= 1'b0;
    end else if (step) begin
      cnt_a_r  <= cnt_a_nxt;
      cnt_b_r  <= cnt_b_nxt;
      frames_r <= frames_nxt;
      kept_r   <= kept_nxt;
      any_r    <= any_nxt;
    end
  end

  // The restart phase ends for good once a frame has completed.
  a_any_sticky: assert property (@(posedge clk) disable iff (!rst_n) any_r |=> any_r)
    else $error("frame-completed flag cleared");
  // A kept photon advances the running count by exactly one.
  a_kept_inc: assert property (@(posedge clk) disable iff (!rst_n)
    step && kept |=> kept_r == $past(kept_r) + 1'b1)
    else $error("kept count did not advance");
  // Counters hold between photons.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(cnt_a_r) && $stable(cnt_b_r) && $stable(frames_r))
    else $error("pack state changed without a photon");

endmodule

`default_nettype wire

FILE: rtl/core/photon_event_frame_binner_unit.sv
// Top level of the photon event frame binner: window test, binning sequencer and result register.
//
//   channel  | direction | handshake          | payload
//   in_      | request   | in_valid/in_stall  | in_event_word
//   out_     | result    | out_valid/out_stall| window flag, pixel index, frame flags, counts
//   config   | APB write | psel/penable/pwrite| paddr, pwdata, prdata, pready
//
// A photon inside the window runs through S_SPAN, S_WIN, S_DIVX, S_DIVY, S_MUL and S_OUT, the
// shared divider running the x and then the y division at two bits per cycle. A photon outside
// the window goes from S_WIN straight to S_OUT. in_stall is high while a photon is in work.
// The result register frees the core: a finished result may wait under out_stall while the
// next photon is taken, and only the hand-over into a still full result register waits.
// Reset is synchronous and clears the sequencer, the result valid flag and the frame counters.
`default_nettype none

module photon_event_frame_binner_unit #(
  parameter int COORD_BITS = pefb_pkg::DEF_COORD_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [pefb_pkg::EVT_W-1:0]   in_event_word,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_in_window,
  output logic      [pefb_pkg::PIX_W-1:0]   out_pixel_index,
  output logic                              out_frame_a_done,
  output logic                              out_frame_b_done,
  output logic                              out_frame_b_restart,
  output logic      [pefb_pkg::FN_W-1:0]    out_frame_number,
  output logic      [pefb_pkg::KT_W-1:0]    out_photons_kept,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pefb_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [pefb_pkg::DATA_W-1:0]  pwdata,
  output logic      [pefb_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);
  import pefb_pkg::*;

  localparam int SPAN_W = SZ_W + RF_W;
  localparam int XW     = SPAN_W + 2;
  localparam int PRODW  = COORD_BITS + SZ_W;
  localparam int unsigned LIM = MAX_IMAGE & ~32'd1;

  typedef enum logic [2:0] {
    S_IDLE, S_SPAN, S_WIN, S_DIVX, S_DIVY, S_MUL, S_OUT
  } state_t;

  // Even size saturated at the image limit.
  function automatic logic [SZ_W-1:0] eff_size(input logic [SZ_W-1:0] v);
    logic [SZ_W-1:0] e;
    e = {v[SZ_W-1:1], 1'b0};
    return (32'(e) > LIM) ? SZ_W'(LIM) : e;
  endfunction

  pefb_cfg_t  cfg;
  pefb_pack_t pack_res;

  state_t                  state_r, state_nxt;
  logic [COORD_BITS-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic [SPAN_W-1:0]       spanx_r, spanx_nxt, spany_r, spany_nxt;
  logic                    inw_r, inw_nxt;
  logic [COORD_BITS-1:0]   dy_r, dy_nxt, bx_r, bx_nxt, by_r, by_nxt;
  logic [PIX_W-1:0]        prod_r, prod_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_inw_r, out_inw_nxt;
  logic [PIX_W-1:0]        out_pix_r, out_pix_nxt;
  pefb_pack_t              out_res_r, out_res_nxt;

  logic [EVT_W-1:0]        swapped;
  logic [SZ_W-1:0]         nx, ny;
  logic [RF_W-1:0]         r;
  logic [XW-1:0]           xs_raw, ys_raw, xs, ys, xe, ye, x_e, y_e, dx_full, dy_full;
  logic                    inw;
  logic [PRODW-1:0]        prod_full;
  logic                    div_start, div_busy, div_done;
  logic [COORD_BITS-1:0]   div_dividend, div_quot;
  logic                    pack_step;

  pefb_regs u_regs (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  pefb_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(r), .busy(div_busy), .done(div_done), .quotient(div_quot)
  );

  pefb_pack u_pack (
    .clk(clk), .rst_n(rst_n), .step(pack_step), .kept(inw_r),
    .pack_size(cfg.pack_size), .res(pack_res)
  );

  // Effective geometry from the registers.
  assign nx = eff_size(cfg.out_width);
  assign ny = eff_size(cfg.out_height);
  assign r  = (cfg.reduce_factor == '0) ? RF_W'(1) : cfg.reduce_factor;

  // File byte order is reversed before the coordinate fields are taken.
  assign swapped = {in_event_word[7:0], in_event_word[15:8],
                    in_event_word[23:16], in_event_word[31:24]};

  // Window start, clamped at zero, and the bounds test.
  always_comb begin
    xs_raw  = XW'(cfg.center_x) - XW'(spanx_r[SPAN_W-1:1]);
    ys_raw  = XW'(cfg.center_y) - XW'(spany_r[SPAN_W-1:1]);
    xs      = xs_raw[XW-1] ? '0 : xs_raw;
    ys      = ys_raw[XW-1] ? '0 : ys_raw;
    xe      = xs + XW'(spanx_r);
    ye      = ys + XW'(spany_r);
    x_e     = XW'(x_r);
    y_e     = XW'(y_r);
    inw     = (x_e >= xs) && (x_e < xe) && (y_e >= ys) && (y_e < ye);
    dx_full = x_e - xs;
    dy_full = y_e - ys;
  end

  assign prod_full = PRODW'(by_r) * PRODW'(nx);
  assign in_stall  = (state_r != S_IDLE);

  // Sequencer and result register next values.
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    spanx_nxt     = spanx_r;
    spany_nxt     = spany_r;
    inw_nxt       = inw_r;
    dy_nxt        = dy_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    prod_nxt      = prod_r;
    out_inw_nxt   = out_inw_r;
    out_pix_nxt   = out_pix_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && out_stall;
    div_start     = 1'b0;
    div_dividend  = dy_r;
    pack_step     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt     = swapped[COORD_BITS-1:0];
          y_nxt     = swapped[2*COORD_BITS-1:COORD_BITS];
          state_nxt = S_SPAN;
        end
      end
      S_SPAN: begin
        spanx_nxt = SPAN_W'(nx) * SPAN_W'(r);
        spany_nxt = SPAN_W'(ny) * SPAN_W'(r);
        state_nxt = S_WIN;
      end
      S_WIN: begin
        inw_nxt  = inw;
        dy_nxt   = dy_full[COORD_BITS-1:0];
        bx_nxt   = '0;
        prod_nxt = '0;
        if (inw) begin
          div_start    = 1'b1;
          div_dividend = dx_full[COORD_BITS-1:0];
          state_nxt    = S_DIVX;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIVX: begin
        if (div_done) begin
          bx_nxt    = div_quot;
          div_start = 1'b1;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          by_nxt    = div_quot;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = prod_full[PIX_W-1:0];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          pack_step     = 1'b1;
          out_valid_nxt = 1'b1;
          out_inw_nxt   = inw_r;
          out_pix_nxt   = inw_r ? PIX_W'(bx_r) + prod_r : '0;
          out_res_nxt   = pack_res;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, control and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    spanx_r   <= spanx_nxt;
    spany_r   <= spany_nxt;
    inw_r     <= inw_nxt;
    dy_r      <= dy_nxt;
    bx_r      <= bx_nxt;
    by_r      <= by_nxt;
    prod_r    <= prod_nxt;
    out_inw_r <= out_inw_nxt;
    out_pix_r <= out_pix_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_in_window       = out_inw_r;
  assign out_pixel_index     = out_pix_r;
  assign out_frame_a_done    = out_res_r.a_done;
  assign out_frame_b_done    = out_res_r.b_done;
  assign out_frame_b_restart = out_res_r.b_restart;
  assign out_frame_number    = out_res_r.frame_number;
  assign out_photons_kept    = out_res_r.photons_kept;

  // A photon outside the window always reports pixel zero.
  a_pix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_in_window || out_pixel_index == '0))
    else $error("nonzero pixel index outside window");
  // The divider is never restarted while it is still stepping.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");
  // Divider completions only arrive while a division is awaited.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVX || state_r == S_DIVY))
    else $error("divider finished outside a division state");
  // A restart of stream B never coincides with a stream A completion.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_b_restart |-> !out_frame_a_done)
    else $error("restart reported together with a frame completion");

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the photon event frame binner: directed table, then randomized phases.
`timescale 1ns / 1ps

module tb;
  import pefb_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 3000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 38;
  localparam int HOLD_PHASE   = 5;
  localparam int QUIET_PHASE  = 6;
  localparam int PAUSE_PHASE  = 7;
  localparam int DRAIN_CYCLES = 40;
  localparam int SHOW_LIMIT   = 10;

  // One binned result as it leaves the block.
  typedef struct packed {
    logic             in_window;
    logic [PIX_W-1:0] pixel_index;
    pefb_pack_t       frame;
  } bin_result_t;

  // Row of the directed table: a register write or one photon request.
  typedef enum logic {ROW_EVENT, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [IDX_W-1:0]  reg_idx;
    logic [DATA_W-1:0] value;
    logic [EVT_W-1:0]  word;
    logic              has_typed;
    bin_result_t       typed;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic [EVT_W-1:0]  in_event_word = '0;
  logic              out_stall = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;

  wire logic              in_stall;
  wire logic              out_valid;
  wire logic              out_in_window;
  wire logic [PIX_W-1:0]  out_pixel_index;
  wire logic              out_frame_a_done;
  wire logic              out_frame_b_done;
  wire logic              out_frame_b_restart;
  wire logic [FN_W-1:0]   out_frame_number;
  wire logic [KT_W-1:0]   out_photons_kept;
  wire logic [DATA_W-1:0] prdata;
  wire logic              pready;

  photon_event_frame_binner_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_event_word       (in_event_word),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_in_window       (out_in_window),
    .out_pixel_index     (out_pixel_index),
    .out_frame_a_done    (out_frame_a_done),
    .out_frame_b_done    (out_frame_b_done),
    .out_frame_b_restart (out_frame_b_restart),
    .out_frame_number    (out_frame_number),
    .out_photons_kept    (out_photons_kept),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the registers and the frame bookkeeping.
  pefb_cfg_t        binner_cfg;
  logic [PS_W-1:0]  pack_a;
  logic [PS_W-1:0]  pack_b;
  logic [FN_W-1:0]  frames;
  logic [KT_W-1:0]  kept;
  logic             any_frame;

  bin_result_t bin_results_due[$];
  stim_row_t   directed_rows[$];

  int tx_idle_pct = 28;
  int rx_idle_pct = 28;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatch_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int frames_seen = 0;
  int restarts_seen = 0;
  int stuck_cycles = 0;

  function automatic void reset_binner_model();
    binner_cfg.center_x      = RST_CENTER;
    binner_cfg.center_y      = RST_CENTER;
    binner_cfg.out_width     = RST_SIZE;
    binner_cfg.out_height    = RST_SIZE;
    binner_cfg.reduce_factor = RST_REDUCE;
    binner_cfg.pack_size     = RST_PACK;
    pack_a    = '0;
    pack_b    = '0;
    frames    = '0;
    kept      = '0;
    any_frame = 1'b0;
  endfunction

  // Binned edge length: bit 0 cleared, then saturated at the even image limit.
  function automatic int unsigned binned_edge(input logic [SZ_W-1:0] size_reg);
    int unsigned lim;
    int unsigned v;
    lim = MAX_IMAGE & ~32'd1;
    v = int'(size_reg) & ~32'd1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic int unsigned reduce_eff();
    return (binner_cfg.reduce_factor == '0) ? 1 : int'(binner_cfg.reduce_factor);
  endfunction

  // Window along one axis: start clamped at zero, end exclusive.
  function automatic void window_span(input logic [CX_W-1:0] ctr, input logic [SZ_W-1:0] size_reg,
                                      output int lo, output int hi);
    int span;
    span = int'(binned_edge(size_reg) * reduce_eff());
    lo = int'(ctr) - span / 2;
    if (lo < 0) lo = 0;
    hi = lo + span;
  endfunction

  // Bins one photon word and advances the frame counters.
  function automatic bin_result_t predict_bin_result(input logic [EVT_W-1:0] raw);
    logic [EVT_W-1:0] w;
    int               x, y, xlo, xhi, ylo, yhi;
    int unsigned      rf, bx, by;
    bin_result_t      res;
    w = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
    x = int'(w[9:0]);
    y = int'(w[19:10]);
    rf = reduce_eff();
    window_span(binner_cfg.center_x, binner_cfg.out_width, xlo, xhi);
    window_span(binner_cfg.center_y, binner_cfg.out_height, ylo, yhi);
    res = '0;
    res.in_window = (x >= xlo) && (x < xhi) && (y >= ylo) && (y < yhi);
    if (res.in_window) begin
      bx = (x - xlo) / rf;
      by = (y - ylo) / rf;
      res.pixel_index = PIX_W'(bx + by * binned_edge(binner_cfg.out_width));
      kept   = kept + 1'b1;
      pack_a = pack_a + 1'b1;
      pack_b = pack_b + 1'b1;
    end
    res.frame.frame_number = frames;
    // Pack checks run on every word, kept or not.
    if (pack_a == binner_cfg.pack_size) begin
      res.frame.a_done = 1'b1;
      pack_a = '0;
      frames = frames + 1'b1;
      any_frame = 1'b1;
    end
    if (!any_frame && pack_a == (binner_cfg.pack_size >> 1)) begin
      res.frame.b_restart = 1'b1;
      pack_b = '0;
    end
    if (pack_b == binner_cfg.pack_size) begin
      res.frame.b_done = 1'b1;
      pack_b = '0;
      frames = frames + 1'b1;
      any_frame = 1'b1;
    end
    res.frame.photons_kept = kept;
    return res;
  endfunction

  // Builds the file word for a detector position: fields packed, then bytes reversed.
  function automatic logic [EVT_W-1:0] photon_word(input int x, input int y, input int t);
    logic [EVT_W-1:0] w;
    w = {t[11:0], y[9:0], x[9:0]};
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // Coordinate near or inside [lo, hi), with the edges hit often.
  function automatic int window_coord(input int lo, input int hi);
    int top;
    int pick;
    top = (hi > 1024) ? 1023 : hi - 1;
    pick = $urandom_range(0, 19);
    case (pick)
      0: return (lo > 0) ? lo - 1 : lo;
      1: return hi;
      2: return lo;
      3: return top;
      default: return $urandom_range(lo, top);
    endcase
  endfunction

  // Mostly photons aimed into the current window, the rest raw noise.
  function automatic logic [EVT_W-1:0] random_photon_word();
    int xlo, xhi, ylo, yhi;
    window_span(binner_cfg.center_x, binner_cfg.out_width, xlo, xhi);
    window_span(binner_cfg.center_y, binner_cfg.out_height, ylo, yhi);
    if ($urandom_range(0, 99) < 25 || xhi <= xlo || yhi <= ylo) return $urandom();
    return photon_word(window_coord(xlo, xhi), window_coord(ylo, yhi), $urandom_range(0, 4095));
  endfunction

  // Register write: setup phase, access phase, then the bus is released and the predictor copy updated.
  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CENTER_X:      binner_cfg.center_x      = value[CX_W-1:0];
      REG_CENTER_Y:      binner_cfg.center_y      = value[CX_W-1:0];
      REG_OUT_WIDTH:     binner_cfg.out_width     = value[SZ_W-1:0];
      REG_OUT_HEIGHT:    binner_cfg.out_height    = value[SZ_W-1:0];
      REG_REDUCE_FACTOR: binner_cfg.reduce_factor = value[RF_W-1:0];
      REG_PACK_SIZE:     binner_cfg.pack_size     = value[PS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offers one photon request, optionally after a gap, and records its expected result.
  task automatic send_photon(input logic [EVT_W-1:0] word, input logic has_typed,
                             input bin_result_t typed);
    bin_result_t pred;
    int          gap;
    gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_event_word <= word;
    do @(posedge clk); while (in_stall);
    pred = predict_bin_result(word);
    bin_results_due.push_back(has_typed ? typed : pred);
    items_sent++;
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (bin_results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Drives both pack counters to zero through out-of-window words on an empty window.
  task automatic clear_pack_counters();
    write_register(REG_OUT_WIDTH, '0);
    write_register(REG_PACK_SIZE, DATA_W'(pack_a));
    send_photon($urandom(), 1'b0, '0);
    wait_results_drained();
    write_register(REG_PACK_SIZE, DATA_W'(pack_b));
    send_photon($urandom(), 1'b0, '0);
    wait_results_drained();
  endtask

  // Picks and writes the register setting of one random phase.
  task automatic configure_phase(input int phase);
    logic [DATA_W-1:0] cx, cy, wd, ht, rf, ps;
    int unsigned       floor_cnt;
    cx = $urandom_range(0, 1023);
    cy = $urandom_range(0, 1023);
    wd = 2 * $urandom_range(1, 128);
    ht = 2 * $urandom_range(1, 128);
    rf = $urandom_range(1, 32);
    // Odd, zero and oversized sizes, and reduce factors outside the usual range.
    if ($urandom_range(0, 3) == 0) wd = $urandom_range(0, 511);
    if ($urandom_range(0, 3) == 0) ht = $urandom_range(0, 511);
    if ($urandom_range(0, 5) == 0) rf = $urandom_range(0, 63);
    // Keep the pack size above both counters so that frames keep completing.
    floor_cnt = (pack_a > pack_b) ? pack_a : pack_b;
    ps = floor_cnt + $urandom_range(1, 12);
    if (ps > 32'hFFFF) ps = 32'hFFFF;
    case (phase)
      0: begin
        cx = 0; cy = 0; wd = 2; ht = 2; rf = 1;
      end
      1: begin
        cx = 1023; cy = 1023; wd = 256; ht = 256; rf = 32;
      end
      2: ps = 32'hFFFF;
      3: begin
        clear_pack_counters();
        ps = 1;
      end
      4: begin
        clear_pack_counters();
        ps = 0;
      end
      default: ;
    endcase
    write_register(REG_CENTER_X, cx);
    write_register(REG_CENTER_Y, cy);
    write_register(REG_OUT_WIDTH, wd);
    write_register(REG_OUT_HEIGHT, ht);
    write_register(REG_REDUCE_FACTOR, rf);
    write_register(REG_PACK_SIZE, ps);
  endtask

  function automatic void add_write_row(input logic [IDX_W-1:0] idx, input int value);
    stim_row_t row;
    row = '{kind: ROW_WRITE, reg_idx: idx, value: DATA_W'(value), word: '0,
            has_typed: 1'b0, typed: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_photon_row(input logic [EVT_W-1:0] word);
    stim_row_t row;
    row = '{kind: ROW_EVENT, reg_idx: '0, value: '0, word: word, has_typed: 1'b0, typed: '0};
    directed_rows.push_back(row);
  endfunction

  // Kept photon with no frame activity, result written out by hand.
  function automatic void add_kept_row(input logic [EVT_W-1:0] word, input int pix, input int n);
    stim_row_t row;
    row = '{kind: ROW_EVENT, reg_idx: '0, value: '0, word: word, has_typed: 1'b1, typed: '0};
    row.typed.in_window = 1'b1;
    row.typed.pixel_index = PIX_W'(pix);
    row.typed.frame.photons_kept = KT_W'(n);
    directed_rows.push_back(row);
  endfunction

  // Result side: checks every accepted result and stalls at random or for a long hold.
  always @(posedge clk) begin
    bin_result_t got;
    bin_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_in_window, out_pixel_index, out_frame_a_done, out_frame_b_done,
             out_frame_b_restart, out_frame_number, out_photons_kept};
      if (bin_results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
          $display("result with nothing expected: win=%0d pix=%0d kept=%0d",
                   got.in_window, got.pixel_index, got.frame.photons_kept);
      end else begin
        want = bin_results_due.pop_front();
        results_seen++;
        frames_seen   += got.frame.a_done + got.frame.b_done;
        restarts_seen += got.frame.b_restart;
        if (got.in_window !== want.in_window || got.pixel_index !== want.pixel_index ||
            got.frame.a_done !== want.frame.a_done || got.frame.b_done !== want.frame.b_done ||
            got.frame.b_restart !== want.frame.b_restart ||
            got.frame.frame_number !== want.frame.frame_number ||
            got.frame.photons_kept !== want.frame.photons_kept) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_LIMIT) begin
            $display("result %0d expected win=%0d pix=%0d a=%0d b=%0d rst=%0d fn=%0d kept=%0d",
                     results_seen, want.in_window, want.pixel_index, want.frame.a_done,
                     want.frame.b_done, want.frame.b_restart, want.frame.frame_number,
                     want.frame.photons_kept);
            $display("result %0d actual   win=%0d pix=%0d a=%0d b=%0d rst=%0d fn=%0d kept=%0d",
                     results_seen, got.in_window, got.pixel_index, got.frame.a_done,
                     got.frame.b_done, got.frame.b_restart, got.frame.frame_number,
                     got.frame.photons_kept);
          end
        end
      end
    end
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Watchdog: ends the run when no request, result or register access moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("no traffic for %0d cycles, %0d results still expected",
               stuck_cycles, bin_results_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stimulus: reset, directed table, then randomized phases.
  initial begin
    reset_binner_model();

    // Whole detector lies in the window after reset, so these results read off directly.
    add_kept_row(photon_word(0, 0, 0), 0, 1);
    add_kept_row(photon_word(1023, 1023, 4095), 65535, 2);
    add_kept_row(photon_word(1023, 0, 0), 255, 3);
    add_kept_row(photon_word(0, 1023, 0), 65280, 4);
    add_kept_row(32'hFFFF_FFFF, 65535, 5);
    add_kept_row(32'h0000_0000, 0, 6);
    add_kept_row(photon_word(0, 0, 4095), 0, 7);
    // Half-pack restart on a kept word, again on an out-of-window word, and window edges.
    add_write_row(REG_PACK_SIZE, 16);
    add_write_row(REG_CENTER_X, 0);
    add_write_row(REG_OUT_WIDTH, 3);
    add_write_row(REG_REDUCE_FACTOR, 1);
    add_photon_row(photon_word(0, 384, 17));
    add_photon_row(photon_word(2, 384, 0));
    add_photon_row(photon_word(1, 639, 0));
    add_photon_row(photon_word(1, 640, 0));
    add_photon_row(photon_word(1, 383, 0));
    // Zero size gives an empty window.
    add_write_row(REG_OUT_WIDTH, 0);
    add_photon_row(photon_word(0, 500, 0));
    // Oversized width saturates, zero reduce factor counts as one.
    add_write_row(REG_OUT_WIDTH, 511);
    add_write_row(REG_REDUCE_FACTOR, 0);
    add_write_row(REG_CENTER_X, 1023);
    add_photon_row(photon_word(895, 500, 0));
    add_photon_row(photon_word(894, 500, 0));
    add_photon_row(photon_word(1023, 384, 0));
    // Largest reduce factor, then enough kept photons to complete the first frame.
    add_write_row(REG_REDUCE_FACTOR, 63);
    add_write_row(REG_CENTER_X, 512);
    add_write_row(REG_OUT_WIDTH, 256);
    add_photon_row(photon_word(1023, 1023, 0));
    add_photon_row(photon_word(62, 63, 0));
    add_photon_row(photon_word(100, 200, 0));
    add_photon_row(photon_word(300, 400, 0));
    add_photon_row(photon_word(500, 600, 0));
    add_photon_row(photon_word(700, 800, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_results_drained();
        write_register(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        send_photon(directed_rows[i].word, directed_rows[i].has_typed, directed_rows[i].typed);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_results_drained();
      tx_idle_pct = (phase == HOLD_PHASE || phase == QUIET_PHASE) ? 0 : 28;
      rx_idle_pct = (phase == QUIET_PHASE) ? 0 : 28;
      configure_phase(phase);
      // Long receiver hold while the sender keeps offering requests.
      if (phase == HOLD_PHASE) hold_seq++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == PAUSE_PHASE && i == PHASE_ITEMS / 2) wait_results_drained();
        send_photon(random_photon_word(), 1'b0, '0);
      end
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d photon requests over %0d register settings, %0d results checked",
             items_sent, PHASES + 4, results_seen);
    $display("%0d frame completions, %0d stream B restarts, %0d photons kept",
             frames_seen, restarts_seen, kept);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
